// File: hdl/rhsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_pkg
// shared types and widths for the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
package rhsv_pkg;

    localparam int CB     = 12;          // channel width
    localparam int DW     = 2 * CB + 3;  // dividend and remainder width
    localparam int DVW    = CB + 3;      // divisor width
    localparam int QDEPTH = 2;           // front to back queue depth
    localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [CB-1:0] hue;
        logic [CB-1:0] saturation;
        logic [CB-1:0] brightness;
    } hsv_t;

    // classified request as it travels through queue and divider
    typedef struct packed {
        logic [DW-1:0]  hrem;
        logic [DW-1:0]  srem;
        logic [DVW-1:0] hden;
        logic [DVW-1:0] sden;
        logic [CB-1:0]  hq;
        logic [CB-1:0]  sq;
        logic           neg;
        logic           hzero;
        logic           szero;
        logic [CB-1:0]  bright;
    } work_t;

endpackage
`default_nettype wire

// File: hdl/rhsv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_front
// accepts pixels, finds max/min, sector and divider operands
// ----------------------------------------------------------------------------
module rhsv_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rhsv_pkg::pixel_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rhsv_pkg::work_t      out_data
);
    import rhsv_pkg::*;

    logic          valid_reg;
    work_t         work_reg;
    work_t         work_next;
    logic [CB-1:0] r, g, b, mx, mn, delta;
    logic          rmax, gmax;
    logic [CB+2:0] mag;

    always_comb begin
        r = in_data.red;
        g = in_data.green;
        b = in_data.blue;
        rmax = (r >= g) && (r >= b);
        gmax = !rmax && (g >= b);
        mx = rmax ? r : (gmax ? g : b);
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        work_next = '0;
        work_next.neg = 1'b0;
        if (rmax) begin
            if (b > g) begin
                mag = (CB+3)'(b - g);
                work_next.neg = 1'b1;
            end else begin
                mag = (CB+3)'(g - b);
            end
        end else if (gmax) begin
            mag = (CB+3)'(b) - (CB+3)'(r) + ((CB+3)'(delta) << 1);
        end else begin
            mag = (CB+3)'(r) - (CB+3)'(g) + ((CB+3)'(delta) << 2);
        end
        work_next.hrem   = DW'(mag) << CB;
        work_next.hden   = (DVW'(delta) << 2) + (DVW'(delta) << 1);
        work_next.srem   = (DW'(delta) << CB) - DW'(delta);
        work_next.sden   = DVW'(mx);
        work_next.hzero  = (delta == '0);
        work_next.szero  = (mx == '0);
        work_next.bright = mx;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/rhsv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module rhsv_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire rhsv_pkg::work_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output rhsv_pkg::work_t     pop_data
);
    import rhsv_pkg::*;

    work_t          mem_reg [QDEPTH];
    logic [QPW-1:0] wr_reg, rd_reg;
    logic [QCW-1:0] cnt_reg;
    logic           push, pop;

    assign push_ready = (cnt_reg != QCW'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    function automatic logic [QPW-1:0] bump(input logic [QPW-1:0] p);
        bump = (p == QPW'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= bump(wr_reg);
            if (pop) rd_reg <= bump(rd_reg);
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCW'(QDEPTH))
        else $error("queue count over depth");
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == QCW'(1) && pop && !push) |=> !pop_valid)
        else $error("queue not empty after last pop");
`endif

endmodule
`default_nettype wire

// File: hdl/rhsv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_back
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rhsv_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rhsv_pkg::work_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rhsv_pkg::hsv_t      out_data
);
    import rhsv_pkg::*;

    work_t         p_reg [CB];
    logic [CB-1:0] v_reg;
    logic [CB-1:0] move;
    work_t         last;

    // a stage moves when empty or when the one after it moves
    always_comb begin
        move[CB-1] = !v_reg[CB-1] || out_ready;
        for (int s = CB - 2; s >= 0; s--) begin
            move[s] = !v_reg[s] || move[s+1];
        end
    end

    assign in_ready = move[0];

    for (genvar s = 0; s < CB; s++) begin : g_stage
        localparam int K = CB - 1 - s;
        work_t   cur, nxt;
        logic    vin;
        logic [DW-1:0] hd, sd;

        always_comb begin
            cur = (s == 0) ? in_data : p_reg[(s == 0) ? 0 : s - 1];
            vin = (s == 0) ? in_valid : v_reg[(s == 0) ? 0 : s - 1];
            hd  = DW'(cur.hden) << K;
            sd  = DW'(cur.sden) << K;
            nxt = cur;
            nxt.hq = {cur.hq[CB-2:0], (cur.hrem >= hd)};
            nxt.sq = {cur.sq[CB-2:0], (cur.srem >= sd)};
            if (cur.hrem >= hd) nxt.hrem = cur.hrem - hd;
            if (cur.srem >= sd) nxt.srem = cur.srem - sd;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (move[s]) begin
                v_reg[s] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (move[s] && vin) p_reg[s] <= nxt;
        end
    end

    assign last      = p_reg[CB-1];
    assign out_valid = v_reg[CB-1];

    always_comb begin
        out_data.brightness = last.bright;
        out_data.saturation = last.szero ? '0 : last.sq;
        if (last.hzero) out_data.hue = '0;
        else if (last.neg) out_data.hue = CB'(~last.hq + 1'b1);
        else out_data.hue = last.hq;
    end

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[0] && !move[0]) |=> (v_reg[0] && $stable(p_reg[0])))
        else $error("stalled stage lost its request");
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_data.brightness == '0) |->
        (out_data.saturation == '0 && out_data.hue == '0))
        else $error("black pixel with nonzero hue or saturation");
`endif

endmodule
`default_nettype wire

// File: hdl/rgb_to_hsv_pixel.sv
`default_nettype none
// throughput: one pixel per cycle while m_ready does not stall the output,
// set by the one-bit-per-stage divider pipeline
// the front register and a two-entry queue let intake go on while results wait
// reset: aresetn synchronous active low, clears all valid flags and queue pointers
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// fixed-point rgb to hsv conversion, front classifier, queue and divider back
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire rhsv_pkg::pixel_t s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output rhsv_pkg::hsv_t       m_data
);
    import rhsv_pkg::*;

    // front to queue request
    logic  f_valid, f_ready;
    work_t f_data;
    // queue to back request
    logic  q_valid, q_ready;
    work_t q_data;

    // max/min, sector choice, numerator sign and divider operands
    rhsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    // decouples front stalls from divider stalls
    rhsv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // hue and saturation quotients, final stage is the output register
    rhsv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// checks the rgb to hsv pixel converter against a fixed-point hsv predictor,
// with a directed table of corner pixels followed by random bursty traffic
// ----------------------------------------------------------------------------
module tb_top;

    import rhsv_pkg::*;

    localparam int N_RANDOM    = 1330;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CB-1:0] FS = {CB{1'b1}};

    // directed row: pixel, and a typed-in hsv where it is obvious
    typedef struct {
        pixel_t px;
        bit     known;
        hsv_t   hsv;
    } pixel_row_t;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    pixel_t s_data = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    hsv_t   m_data;

    hsv_t       hsv_pending[$];
    pixel_row_t pixel_table[$];
    int         mismatches = 0;
    int         table_errs = 0;
    int         cycles = 0;

    always #2 aclk = ~aclk;

    rgb_to_hsv_pixel dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // fixed-point hsv of one pixel
    function automatic hsv_t hsv_of(pixel_t p);
        longint r, g, b, mx, mn, dl, num, h, s;
        hsv_t res;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl = mx - mn;
        s = (mx != 0) ? (dl * FS) / mx : 0;
        h = 0;
        if (dl != 0) begin
            // ties favor red, then green
            if (mx == r) num = g - b;
            else if (mx == g) num = (b - r) + 2 * dl;
            else num = (r - g) + 4 * dl;
            h = (num * (longint'(1) << CB)) / (6 * dl);   // truncates toward zero
            if (num < 0) h += longint'(1) << CB;
        end
        res.hue = h[CB-1:0];
        res.saturation = s[CB-1:0];
        res.brightness = mx[CB-1:0];
        return res;
    endfunction

    function automatic pixel_row_t mk_row(int r, int g, int b, bit known = 0,
                                          int h = 0, int s = 0, int v = 0);
        pixel_row_t row;
        row.px = '{red: r[CB-1:0], green: g[CB-1:0], blue: b[CB-1:0]};
        row.known = known;
        row.hsv = '{hue: h[CB-1:0], saturation: s[CB-1:0], brightness: v[CB-1:0]};
        return row;
    endfunction

    // one request, with a random gap ahead of it now and then
    task automatic send_pixel(pixel_t p, int gap);
        repeat (gap) @(negedge aclk) s_valid <= 1'b0;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [CB-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FS;
            2: return CB'($urandom_range(0, 7));
            3: return FS - CB'($urandom_range(0, 7));
            default: return CB'($urandom_range(0, FS));
        endcase
    endfunction

    // record the expectation at the accepting edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) hsv_pending.push_back(hsv_of(s_data));
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (hsv_pending.size() == 0) begin
                mismatches++;
                if (mismatches + table_errs <= 10) $display("unexpected result %h", m_data);
            end else begin
                hsv_t want;
                want = hsv_pending.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches + table_errs <= 10)
                        $display("mismatch: want h %0d s %0d v %0d, got h %0d s %0d v %0d",
                                 want.hue, want.saturation, want.brightness,
                                 m_data.hue, m_data.saturation, m_data.brightness);
                end
            end
        end
    end

    // receiver stalls: alternating stretches of free flow and random stalling
    always @(negedge aclk) begin
        if (((cycles / 300) % 3) == 0) m_ready <= 1'b1;
        else if (((cycles / 300) % 3) == 1) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= ($urandom_range(0, 1) != 0);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int burst;
        pixel_t p;
        hsv_t v;

        // corner pixels: black, white, greys, primaries, ties, small negative hue
        pixel_table.push_back(mk_row(0, 0, 0, 1, 0, 0, 0));
        pixel_table.push_back(mk_row(FS, FS, FS, 1, 0, 0, FS));
        pixel_table.push_back(mk_row(1, 1, 1, 1, 0, 0, 1));
        pixel_table.push_back(mk_row(2048, 2048, 2048, 1, 0, 0, 2048));
        pixel_table.push_back(mk_row(FS, 0, 0, 1, 0, FS, FS));
        pixel_table.push_back(mk_row(0, FS, 0));
        pixel_table.push_back(mk_row(0, 0, FS));
        pixel_table.push_back(mk_row(FS, FS, 0));
        pixel_table.push_back(mk_row(0, FS, FS));
        pixel_table.push_back(mk_row(FS, 0, FS));
        pixel_table.push_back(mk_row(1, 0, 0, 1, 0, FS, 1));
        pixel_table.push_back(mk_row(FS, 0, 1));
        pixel_table.push_back(mk_row(FS, FS - 1, FS));
        pixel_table.push_back(mk_row(FS, 1, 0));
        pixel_table.push_back(mk_row(0, 1, 1));
        pixel_table.push_back(mk_row(100, 200, 200));
        pixel_table.push_back(mk_row(FS, 2730, 1365));
        pixel_table.push_back(mk_row(1365, 2730, FS));
        pixel_table.push_back(mk_row(12'haaa, 12'h555, 12'h000));
        pixel_table.push_back(mk_row(12'h555, 12'haaa, 12'h800));
        pixel_table.push_back(mk_row(12'h800, 12'h7ff, 12'h801));

        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (pixel_table[i]) begin
            if (pixel_table[i].known) begin
                v = hsv_of(pixel_table[i].px);
                if (v !== pixel_table[i].hsv) begin
                    table_errs++;
                    if (mismatches + table_errs <= 10)
                        $display("table row %0d: typed %h, predicted %h",
                                 i, pixel_table[i].hsv, v);
                end
            end
            send_pixel(pixel_table[i].px, 0);
        end

        // random part in bursts
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            int gap;
            gap = 0;
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap = $urandom_range(0, 6);
            end
            burst--;
            p.red = rand_chan();
            p.green = rand_chan();
            p.blue = rand_chan();
            if ($urandom_range(0, 9) == 0) p.green = p.red;   // channel ties
            if ($urandom_range(0, 9) == 0) p.blue = p.green;
            send_pixel(p, gap);
        end
        @(negedge aclk) s_valid <= 1'b0;

        while (hsv_pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && table_errs == 0 && hsv_pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
